>>> rtl/core/erc_pkg.sv
// Package for the ESC range calibration sequencer.
// Holds register indexes, phase and step codes and the constants for whole seconds.
// No dependencies.
package erc_pkg;

    // Configuration port shape.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 16;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 3;
    localparam int SECS_W     = 7;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_BAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MAX_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN_MS   = 3'd4;

    // Reset values, given for a 12-bit stick and scaled to other widths.
    localparam int REF_STICK_BITS    = 12;
    localparam int RST_MAX_THRESHOLD = 3800;
    localparam int RST_MIN_THRESHOLD = 200;
    localparam int RST_NEUTRAL_BAND  = 200;
    localparam logic [HOLD_W-1:0] RST_HOLD_MAX_MS = 16'd3000;
    localparam logic [HOLD_W-1:0] RST_HOLD_MIN_MS = 16'd2000;

    // Milliseconds to seconds: x / 1000 == (x * 67109) >> 26 for any 16-bit x.
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 17'd67109;

    // Calibration phases, one-hot.
    typedef enum logic [5:0] {
        PH_WAIT_MAX     = 6'b000001,
        PH_HOLD_MAX     = 6'b000010,
        PH_WAIT_MIN     = 6'b000100,
        PH_HOLD_MIN     = 6'b001000,
        PH_WAIT_NEUTRAL = 6'b010000,
        PH_COMPLETE     = 6'b100000
    } t_phase;

    // Step numbers shown to the user.
    localparam logic [STEP_W-1:0] STEP_DONE         = 3'd0;
    localparam logic [STEP_W-1:0] STEP_WAIT_MAX     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HOLD_MAX     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WAIT_MIN     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_HOLD_MIN     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_WAIT_NEUTRAL = 3'd5;

endpackage

>>> rtl/core/erc_in_if.sv
// Input channel of the calibration sequencer: one stick sample beat.
// Depends on erc_pkg for the timestamp width.
interface erc_in_if #(
    parameter int STICK_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic                        restart;
    logic [STICK_BITS-1:0]       stick_y;
    logic [erc_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output restart, output stick_y, output now_ms,
                    input ready);
    modport sink   (input valid, input restart, input stick_y, input now_ms,
                    output ready);
endinterface

>>> rtl/core/erc_out_if.sv
// Output channel of the calibration sequencer: one result beat per sample.
// Depends on erc_pkg for the step and seconds widths.
interface erc_out_if #(
    parameter int STICK_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic [STICK_BITS-1:0]       drive_y;
    logic [erc_pkg::STEP_W-1:0]  display_step;
    logic [erc_pkg::SECS_W-1:0]  seconds_left;
    logic                        complete;
    logic [STICK_BITS-1:0]       captured_max;
    logic [STICK_BITS-1:0]       captured_min;

    modport source (output valid, output drive_y, output display_step,
                    output seconds_left, output complete, output captured_max,
                    output captured_min, input ready);
    modport sink   (input valid, input drive_y, input display_step,
                    input seconds_left, input complete, input captured_max,
                    input captured_min, output ready);
endinterface

>>> rtl/core/erc_cfg_regs.sv
// Configuration register file of the calibration sequencer.
// Depends on erc_pkg for register indexes and reset values.
module erc_cfg_regs #(
    parameter int STICK_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [erc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [erc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [STICK_BITS-1:0]           o_max_threshold,
    output logic [STICK_BITS-1:0]           o_min_threshold,
    output logic [STICK_BITS-2:0]           o_neutral_band,
    output logic [erc_pkg::HOLD_W-1:0]      o_hold_max_ms,
    output logic [erc_pkg::HOLD_W-1:0]      o_hold_min_ms
);

    // Reset values scaled from the 12-bit figures to this stick width.
    localparam int SCALE_UP = (STICK_BITS >= erc_pkg::REF_STICK_BITS)
                              ? STICK_BITS - erc_pkg::REF_STICK_BITS : 0;
    localparam int SCALE_DN = (STICK_BITS < erc_pkg::REF_STICK_BITS)
                              ? erc_pkg::REF_STICK_BITS - STICK_BITS : 0;
    localparam logic [STICK_BITS-1:0] RST_MAX =
        STICK_BITS'((erc_pkg::RST_MAX_THRESHOLD << SCALE_UP) >> SCALE_DN);
    localparam logic [STICK_BITS-1:0] RST_MIN =
        STICK_BITS'((erc_pkg::RST_MIN_THRESHOLD << SCALE_UP) >> SCALE_DN);
    localparam logic [STICK_BITS-2:0] RST_BAND =
        (STICK_BITS-1)'((erc_pkg::RST_NEUTRAL_BAND << SCALE_UP) >> SCALE_DN);

    logic [STICK_BITS-1:0]      r_max_threshold;
    logic [STICK_BITS-1:0]      r_min_threshold;
    logic [STICK_BITS-2:0]      r_neutral_band;
    logic [erc_pkg::HOLD_W-1:0] r_hold_max_ms;
    logic [erc_pkg::HOLD_W-1:0] r_hold_min_ms;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_threshold <= RST_MAX;
            r_min_threshold <= RST_MIN;
            r_neutral_band  <= RST_BAND;
            r_hold_max_ms   <= erc_pkg::RST_HOLD_MAX_MS;
            r_hold_min_ms   <= erc_pkg::RST_HOLD_MIN_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                erc_pkg::CFG_MAX_THRESHOLD: r_max_threshold <= i_cfg_data[STICK_BITS-1:0];
                erc_pkg::CFG_MIN_THRESHOLD: r_min_threshold <= i_cfg_data[STICK_BITS-1:0];
                erc_pkg::CFG_NEUTRAL_BAND:  r_neutral_band  <= i_cfg_data[STICK_BITS-2:0];
                erc_pkg::CFG_HOLD_MAX_MS:   r_hold_max_ms   <= i_cfg_data[erc_pkg::HOLD_W-1:0];
                erc_pkg::CFG_HOLD_MIN_MS:   r_hold_min_ms   <= i_cfg_data[erc_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_max_threshold = r_max_threshold;
    assign o_min_threshold = r_min_threshold;
    assign o_neutral_band  = r_neutral_band;
    assign o_hold_max_ms   = r_hold_max_ms;
    assign o_hold_min_ms   = r_hold_min_ms;

endmodule

>>> rtl/core/erc_step_logic.sv
// Phase state and per-sample decision logic of the calibration sequencer.
// Depends on erc_pkg for phase codes, step codes and the seconds reciprocal.
module erc_step_logic #(
    parameter int STICK_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic                            i_restart,
    input  logic [STICK_BITS-1:0]           i_stick,
    input  logic [erc_pkg::TIME_W-1:0]      i_now,
    input  logic [STICK_BITS-1:0]           i_max_threshold,
    input  logic [STICK_BITS-1:0]           i_min_threshold,
    input  logic [STICK_BITS-2:0]           i_neutral_band,
    input  logic [erc_pkg::HOLD_W-1:0]      i_hold_max_ms,
    input  logic [erc_pkg::HOLD_W-1:0]      i_hold_min_ms,
    output logic [STICK_BITS-1:0]           o_drive_y,
    output logic [erc_pkg::STEP_W-1:0]      o_display_step,
    output logic [erc_pkg::SECS_W-1:0]      o_seconds_left,
    output logic                            o_complete,
    output logic [STICK_BITS-1:0]           o_captured_max,
    output logic [STICK_BITS-1:0]           o_captured_min
);

    localparam int HW = erc_pkg::HOLD_W;
    localparam int TW = erc_pkg::TIME_W;
    localparam int PW = HW + erc_pkg::RECIP_W;
    localparam logic [STICK_BITS-1:0] CENTER = STICK_BITS'(1) << (STICK_BITS - 1);
    localparam logic [STICK_BITS-1:0] FULL   = '1;

    erc_pkg::t_phase         r_phase, n_phase, ph;
    logic [TW-1:0]           r_start, n_start, start;
    logic [STICK_BITS-1:0]   r_max_seen, n_max_seen;
    logic [STICK_BITS-1:0]   r_min_seen, n_min_seen;

    logic [TW-1:0]           elapsed;
    logic [HW-1:0]           hold_sel;
    logic                    hold_done;
    logic [HW-1:0]           remain;
    logic [PW-1:0]           prod;
    logic [erc_pkg::SECS_W-1:0] hold_secs;
    logic [STICK_BITS-1:0]   center_dist;

    // Restart takes effect before the sample is handled.
    assign ph    = i_restart ? erc_pkg::PH_WAIT_MAX : r_phase;
    assign start = i_restart ? i_now : r_start;

    // Shared hold timer: elapsed time, expiry and whole seconds left plus one.
    assign hold_sel  = (ph == erc_pkg::PH_HOLD_MAX) ? i_hold_max_ms : i_hold_min_ms;
    assign elapsed   = i_now - start;
    assign hold_done = elapsed >= {{(TW-HW){1'b0}}, hold_sel};
    assign remain    = hold_done ? '0 : hold_sel - elapsed[HW-1:0];
    assign prod      = PW'(remain) * PW'(erc_pkg::RECIP_1000);
    assign hold_secs = prod[erc_pkg::RECIP_SHIFT +: erc_pkg::SECS_W] + erc_pkg::SECS_W'(1);

    // Distance of the sample from center for the neutral check.
    assign center_dist = (i_stick >= CENTER) ? i_stick - CENTER : CENTER - i_stick;

    // Phase decision and result fields for this sample.
    always_comb begin
        n_phase        = ph;
        n_start        = start;
        n_max_seen     = i_restart ? '0 : r_max_seen;
        n_min_seen     = i_restart ? '0 : r_min_seen;
        o_drive_y      = i_stick;
        o_display_step = erc_pkg::STEP_DONE;
        o_seconds_left = '0;
        o_complete     = 1'b0;
        unique case (ph)
            erc_pkg::PH_WAIT_MAX: begin
                o_display_step = erc_pkg::STEP_WAIT_MAX;
                if (i_stick >= i_max_threshold) begin
                    n_max_seen = i_stick;
                    n_phase    = erc_pkg::PH_HOLD_MAX;
                    n_start    = i_now;
                end
            end
            erc_pkg::PH_HOLD_MAX: begin
                o_display_step = erc_pkg::STEP_HOLD_MAX;
                o_seconds_left = hold_secs;
                o_drive_y      = FULL;
                if (hold_done) begin
                    n_phase = erc_pkg::PH_WAIT_MIN;
                    n_start = i_now;
                end
            end
            erc_pkg::PH_WAIT_MIN: begin
                o_display_step = erc_pkg::STEP_WAIT_MIN;
                if (i_stick <= i_min_threshold) begin
                    n_min_seen = i_stick;
                    n_phase    = erc_pkg::PH_HOLD_MIN;
                    n_start    = i_now;
                end
            end
            erc_pkg::PH_HOLD_MIN: begin
                o_display_step = erc_pkg::STEP_HOLD_MIN;
                o_seconds_left = hold_secs;
                o_drive_y      = '0;
                if (hold_done) begin
                    n_phase = erc_pkg::PH_WAIT_NEUTRAL;
                    n_start = i_now;
                end
            end
            erc_pkg::PH_WAIT_NEUTRAL: begin
                o_display_step = erc_pkg::STEP_WAIT_NEUTRAL;
                if (center_dist <= {1'b0, i_neutral_band}) begin
                    n_phase        = erc_pkg::PH_COMPLETE;
                    o_display_step = erc_pkg::STEP_DONE;
                    o_complete     = 1'b1;
                end
            end
            default: begin
                // Complete, and any code that should never appear.
                o_drive_y  = CENTER;
                o_complete = 1'b1;
            end
        endcase
    end

    assign o_captured_max = n_max_seen;
    assign o_captured_min = n_min_seen;

    // State advances only when a sample moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= erc_pkg::PH_WAIT_MAX;
            r_start    <= '0;
            r_max_seen <= '0;
            r_min_seen <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_start    <= n_start;
            r_max_seen <= n_max_seen;
            r_min_seen <= n_min_seen;
        end
    end

`ifndef SYNTHESIS
    // Without a sample moving on, the phase and its start time stay put.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_phase) && $stable(r_start))
        else $error("phase state changed without a sample");

    // Seconds are only reported in the hold steps.
    a_secs_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seconds_left != '0) |->
            (o_display_step == erc_pkg::STEP_HOLD_MAX ||
             o_display_step == erc_pkg::STEP_HOLD_MIN))
        else $error("seconds left outside a hold step");

    // A restart below the max threshold leaves both captures cleared.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_restart && (i_stick < i_max_threshold) |=>
            (r_max_seen == '0) && (r_min_seen == '0) &&
            (r_phase == erc_pkg::PH_WAIT_MAX))
        else $error("restart did not clear the captures");
`endif

endmodule

>>> rtl/core/esc_range_calibration_sequencer_unit.sv
// ESC range calibration sequencer: input register, step logic, result register.
// Depends on erc_pkg, erc_in_if, erc_out_if, erc_cfg_regs and erc_step_logic.
//
// Usage:
//   i_in carries one stick sample beat (restart, stick_y, now_ms) with valid/ready.
//   o_out returns exactly one result beat per sample, in order, with valid/ready.
//   The configuration port writes register i_cfg_index with i_cfg_data at any
//   edge where i_cfg_we is high; write it only while no beat is in flight.
// Path: an accepted sample waits in the input register, then moves into the result
//   register, which presents it on o_out.
// Throughput: one beat per cycle while o_out.ready stays high. The phase and timer
//   state in the step logic update as each sample advances, so each sample sees
//   the state left by the previous one without waiting.
// Reset: synchronous, active low. The registers return to their defaults, the
//   phase goes to wait-for-max with the start time and captures at zero, and
//   both channel stages are emptied.
// Stall: while o_out.ready is low the result register holds its beat; one more
//   sample may wait in the input register, after which i_in.ready drops.
module esc_range_calibration_sequencer_unit #(
    parameter int STICK_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [erc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [erc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    erc_in_if.sink                          i_in,
    erc_out_if.source                       o_out
);

    logic [STICK_BITS-1:0]      max_threshold;
    logic [STICK_BITS-1:0]      min_threshold;
    logic [STICK_BITS-2:0]      neutral_band;
    logic [erc_pkg::HOLD_W-1:0] hold_max_ms;
    logic [erc_pkg::HOLD_W-1:0] hold_min_ms;

    logic                       r_in_valid;
    logic                       r_in_restart;
    logic [STICK_BITS-1:0]      r_in_stick;
    logic [erc_pkg::TIME_W-1:0] r_in_now;

    logic                       r_out_valid;
    logic [STICK_BITS-1:0]      r_out_drive_y, n_out_drive_y;
    logic [erc_pkg::STEP_W-1:0] r_out_step, n_out_step;
    logic [erc_pkg::SECS_W-1:0] r_out_secs, n_out_secs;
    logic                       r_out_complete, n_out_complete;
    logic [STICK_BITS-1:0]      r_out_max, n_out_max;
    logic [STICK_BITS-1:0]      r_out_min, n_out_min;

    logic                       s2_ready;
    logic                       s1_ready;
    logic                       advance;

    erc_cfg_regs #(
        .STICK_BITS (STICK_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_max_threshold (max_threshold),
        .o_min_threshold (min_threshold),
        .o_neutral_band  (neutral_band),
        .o_hold_max_ms   (hold_max_ms),
        .o_hold_min_ms   (hold_min_ms)
    );

    // Stage handshake: the result register frees up when empty or taken.
    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s1_ready   = !r_in_valid || s2_ready;
    assign advance    = r_in_valid && s2_ready;
    assign i_in.ready = s1_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s1_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && s1_ready) begin
            r_in_restart <= i_in.restart;
            r_in_stick   <= i_in.stick_y;
            r_in_now     <= i_in.now_ms;
        end
    end

    erc_step_logic #(
        .STICK_BITS (STICK_BITS)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_restart       (r_in_restart),
        .i_stick         (r_in_stick),
        .i_now           (r_in_now),
        .i_max_threshold (max_threshold),
        .i_min_threshold (min_threshold),
        .i_neutral_band  (neutral_band),
        .i_hold_max_ms   (hold_max_ms),
        .i_hold_min_ms   (hold_min_ms),
        .o_drive_y       (n_out_drive_y),
        .o_display_step  (n_out_step),
        .o_seconds_left  (n_out_secs),
        .o_complete      (n_out_complete),
        .o_captured_max  (n_out_max),
        .o_captured_min  (n_out_min)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_drive_y  <= n_out_drive_y;
            r_out_step     <= n_out_step;
            r_out_secs     <= n_out_secs;
            r_out_complete <= n_out_complete;
            r_out_max      <= n_out_max;
            r_out_min      <= n_out_min;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_y      = r_out_drive_y;
    assign o_out.display_step = r_out_step;
    assign o_out.seconds_left = r_out_secs;
    assign o_out.complete     = r_out_complete;
    assign o_out.captured_max = r_out_max;
    assign o_out.captured_min = r_out_min;

`ifndef SYNTHESIS
    // A sample waiting behind a stalled result is neither lost nor altered.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s2_ready |=> r_in_valid && $stable(r_in_now) &&
            $stable(r_in_stick) && $stable(r_in_restart))
        else $error("waiting sample lost or changed");

    // Every sample that leaves the input register lands in the result register.
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("sample dropped between stages");

    // An empty input register always takes a new beat.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input refused while the input register is empty");
`endif

endmodule
